// ===== hw/rtl/ray_sphere_intercept_distance_core_macros.svh =====
// Assertion macros for the ray/sphere intercept core.
`ifndef RAY_SPHERE_INTERCEPT_DISTANCE_CORE_MACROS_SVH
`define RAY_SPHERE_INTERCEPT_DISTANCE_CORE_MACROS_SVH

// clocked assertion, off during reset
`define RSID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication shorthand
`define RSID_ASSERT_IMP(lbl, ante, cons, msg) \
  `RSID_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/rsid_pkg.sv =====
// Types and constants shared by the ray/sphere intercept core.
package rsid_pkg;

  localparam int unsigned DIR_FRAC = 30;
  localparam int unsigned B_W      = 35;           // |b| < 2^34
  localparam int unsigned RAD_W    = 70;           // discriminant < 2^69
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned REM_W    = ROOT_W + 2;
  localparam int unsigned DIST_W   = B_W + 1;
  localparam int unsigned RADIUS_W = 31;
  localparam int unsigned TOL_W    = 16;
  localparam int unsigned CFG_W    = 31;

  localparam logic CFG_RADIUS = 1'b0;
  localparam logic CFG_TOL    = 1'b1;

  localparam logic [RADIUS_W-1:0] RADIUS_RST = 31'd65536;
  localparam logic [TOL_W-1:0]    TOL_RST    = 16'd1;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] distance;
    logic        saturated;
  } out_word_t;

  // travels alongside the square root
  typedef struct packed {
    logic           miss;
    logic           bneg;
    logic [B_W-1:0] bmag;
  } side_t;

endpackage

// ===== hw/rtl/rsid_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, with sideband.
module rsid_isqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  output logic                        ready_o,
  input  logic [rsid_pkg::RAD_W-1:0]  rad_i,
  input  rsid_pkg::side_t             side_i,
  output logic                        valid_o,
  input  logic                        ready_i,
  output logic [rsid_pkg::ROOT_W-1:0] root_o,
  output rsid_pkg::side_t             side_o
);
  import rsid_pkg::*;

  logic [ROOT_W-1:0][RAD_W-1:0]  rad;
  logic [ROOT_W-1:0][REM_W-1:0]  rem;
  logic [ROOT_W:0][ROOT_W-1:0]   root;
  side_t                         side [ROOT_W+1];
  logic [ROOT_W:0]               vld;
  logic [ROOT_W+1:1]             rdy;

  assign rad[0]  = rad_i;
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign side[0] = side_i;
  assign vld[0]  = valid_i;
  assign rdy[ROOT_W+1] = ready_i;

  for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;
    logic [REM_W+1:0]  rem_nx;
    logic [ROOT_W-1:0] root_nx;

    always_comb begin
      rem_sh  = {rem[j], rad[j][RAD_W-1 -: 2]};
      trial   = (REM_W+2)'({root[j], 2'b01});
      ge      = rem_sh >= trial;
      rem_nx  = ge ? rem_sh - trial : rem_sh;
      root_nx = {root[j][ROOT_W-2:0], ge};
    end

    assign rdy[j+1] = !vld[j+1] || rdy[j+2];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld[j+1] <= 1'b0;
      end else if (rdy[j+1]) begin
        vld[j+1] <= vld[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j+1]) begin
        root[j+1] <= root_nx;
        side[j+1] <= side[j];
      end
    end

    if (j < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (rdy[j+1]) begin
          rem[j+1] <= rem_nx[REM_W-1:0];
          rad[j+1] <= {rad[j][RAD_W-3:0], 2'b00};
        end
      end
    end
  end

  assign ready_o = rdy[1];
  assign valid_o = vld[ROOT_W];
  assign root_o  = root[ROOT_W];
  assign side_o  = side[ROOT_W];

endmodule

// ===== hw/rtl/ray_sphere_intercept_distance_core.sv =====
// Ray/sphere intercept distance core: top level.
//
// Input channel in_valid_i/in_ready_o carries one ray word (origin Q16.16,
// direction Q2.30). Output channel out_valid_o/out_ready_i returns one word
// per ray: hit flag, Q16.16 distance (zero on a miss) and saturation flag.
// The user writes sphere radius and surface tolerance through cfg_we_i /
// cfg_idx_i / cfg_data_i only while no ray is in flight; not enforced here.
// The pipe holds four arithmetic stages (products, sums, b squared,
// discriminant), 35 stages of the bit-per-stage square root, and the
// output register. One ray is taken every cycle while in_ready_o is high.
// Every stage advances when its successor is empty or advancing, so a
// stalled receiver stops only the full part of the pipe; bubbles still
// fill, and in_ready_o falls only once every stage holds a word.
// Reset empties the pipe and sets radius 1.0 and tolerance 1 LSB.
module ray_sphere_intercept_distance_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  rsid_pkg::in_word_t         in_word_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output rsid_pkg::out_word_t        out_word_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [rsid_pkg::CFG_W-1:0] cfg_data_i
);
  import rsid_pkg::*;

  `include "ray_sphere_intercept_distance_core_macros.svh"

  logic [RADIUS_W-1:0] radius_q;
  logic [TOL_W-1:0]    tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      tol_q    <= TOL_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_RADIUS: radius_q <= cfg_data_i[RADIUS_W-1:0];
        CFG_TOL:    tol_q    <= cfg_data_i[TOL_W-1:0];
        default:    ;
      endcase
    end
  end

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy_out;
  logic sq_valid;

  // stage 1: products
  logic signed [63:0] pp_q [3];
  logic signed [63:0] pd_q [3];
  logic [61:0]        rr1_q, lo2_1_q;
  logic [63:0]        up2_1_q;
  logic               rlt1_q;
  logic [31:0]        up;
  logic [RADIUS_W-1:0] lo;

  assign up = 32'(radius_q) + 32'(tol_q);
  assign lo = (radius_q >= RADIUS_W'(tol_q)) ? radius_q - RADIUS_W'(tol_q) : '0;

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pp_q[0] <= 64'(in_word_i.pos_x) * 64'(in_word_i.pos_x);
      pp_q[1] <= 64'(in_word_i.pos_y) * 64'(in_word_i.pos_y);
      pp_q[2] <= 64'(in_word_i.pos_z) * 64'(in_word_i.pos_z);
      pd_q[0] <= 64'(in_word_i.pos_x) * 64'(in_word_i.dir_x);
      pd_q[1] <= 64'(in_word_i.pos_y) * 64'(in_word_i.dir_y);
      pd_q[2] <= 64'(in_word_i.pos_z) * 64'(in_word_i.dir_z);
      rr1_q   <= 62'(radius_q) * 62'(radius_q);
      up2_1_q <= 64'(up) * 64'(up);
      lo2_1_q <= 62'(lo) * 62'(lo);
      rlt1_q  <= radius_q < RADIUS_W'(tol_q);
    end
  end

  // stage 2: |pos|^2 and b = floor(pos.dir / 2^30)
  logic [63:0]          r2_2_q;
  logic signed [B_W-1:0] b2_q;
  logic [61:0]          rr2_q, lo2_2_q;
  logic [63:0]          up2_2_q;
  logic                 rlt2_q;
  logic signed [65:0]   bsum;

  assign bsum = 66'(pd_q[0]) + 66'(pd_q[1]) + 66'(pd_q[2]);

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      r2_2_q  <= 64'(pp_q[0]) + 64'(pp_q[1]) + 64'(pp_q[2]);
      b2_q    <= bsum[DIR_FRAC+B_W-1:DIR_FRAC];
      rr2_q   <= rr1_q;
      up2_2_q <= up2_1_q;
      lo2_2_q <= lo2_1_q;
      rlt2_q  <= rlt1_q;
    end
  end

  // stage 3: surface test, |b| and b squared
  logic [63:0]      r2_3_q;
  logic [61:0]      rr3_q;
  logic [RAD_W-1:0] bsq3_q;
  logic [B_W-1:0]   bmag3_q;
  logic             bneg3_q, tolmiss3_q;
  logic [B_W-1:0]   bmag;

  assign bmag = b2_q[B_W-1] ? B_W'(-b2_q) : B_W'(b2_q);

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      r2_3_q     <= r2_2_q;
      rr3_q      <= rr2_q;
      bsq3_q     <= RAD_W'(bmag) * RAD_W'(bmag);
      bmag3_q    <= bmag;
      bneg3_q    <= b2_q[B_W-1];
      tolmiss3_q <= (r2_2_q < up2_2_q) && (rlt2_q || (64'(lo2_2_q) < r2_2_q));
    end
  end

  // stage 4: discriminant
  logic [RAD_W-1:0] rad4_q;
  side_t            side4_q;
  logic [RAD_W-1:0] tt;
  logic             dneg;

  assign tt   = bsq3_q + RAD_W'(rr3_q);
  assign dneg = tt < RAD_W'(r2_3_q);

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      rad4_q       <= dneg ? '0 : tt - RAD_W'(r2_3_q);
      side4_q.miss <= tolmiss3_q || dneg;
      side4_q.bneg <= bneg3_q;
      side4_q.bmag <= bmag3_q;
    end
  end

  assign rdy_out = !out_valid_o || out_ready_i;
  assign rdy3    = !v3_q || rdy4;
  assign rdy2    = !v2_q || rdy3;
  assign rdy1    = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  logic sq_ready;
  assign rdy4 = !v4_q || sq_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  logic [ROOT_W-1:0] root;
  side_t             sq_side;

  rsid_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v4_q),
    .ready_o (sq_ready),
    .rad_i   (rad4_q),
    .side_i  (side4_q),
    .valid_o (sq_valid),
    .ready_i (rdy_out),
    .root_o  (root),
    .side_o  (sq_side)
  );

  // output stage: pick the nearest positive root, clamp
  logic [DIST_W-1:0] dist_raw;
  logic              hit;
  out_word_t         out_d, out_q;
  logic              ovld_q;

  always_comb begin
    dist_raw = '0;
    hit      = 1'b0;
    if (!sq_side.miss) begin
      if (sq_side.bneg) begin
        hit      = 1'b1;
        dist_raw = (sq_side.bmag > root) ? DIST_W'(sq_side.bmag - root)
                                         : DIST_W'(sq_side.bmag) + DIST_W'(root);
      end else if (root > sq_side.bmag) begin
        hit      = 1'b1;
        dist_raw = DIST_W'(root - sq_side.bmag);
      end
    end
    out_d.hit       = hit;
    out_d.saturated = hit && (dist_raw[DIST_W-1:32] != '0);
    out_d.distance  = out_d.saturated ? '1 : dist_raw[31:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovld_q <= 1'b0;
    end else if (rdy_out) begin
      ovld_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = ovld_q;
  assign out_word_o  = out_q;

  `RSID_ASSERT_IMP(a_miss_zero, out_valid_o && !out_word_o.hit,
                   out_word_o.distance == '0 && !out_word_o.saturated, "miss with payload")
  `RSID_ASSERT_IMP(a_sat_clamp, out_valid_o && out_word_o.saturated,
                   out_word_o.distance == '1, "saturated distance not clamped")
  `RSID_ASSERT_IMP(a_full_stall, !in_ready_o,
                   out_valid_o && !out_ready_i, "input blocked without output stall")

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the ray/sphere intercept distance core: random and directed rays, self-checked.
`timescale 1ns / 100ps

module tb_top;
  import rsid_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 60;
  localparam int unsigned LONG_HOLD   = 300;

  logic            clk_i;
  logic            rst_ni;
  logic            in_valid_i;
  logic            in_ready_o;
  in_word_t        in_word_i;
  logic            out_valid_o;
  logic            out_ready_i;
  out_word_t       out_word_o;
  logic            cfg_we_i;
  logic            cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  ray_sphere_intercept_distance_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_word_i  (in_word_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_word_o (out_word_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // local copy of the sphere registers
  logic [RADIUS_W-1:0] radius_q = RADIUS_RST;
  logic [TOL_W-1:0]    tol_q    = TOL_RST;

  in_word_t  ray_queue[$];
  out_word_t hit_queue[$];
  int unsigned mismatches = 0;
  int unsigned cycles     = 0;
  int unsigned tx_gap     = 0;
  int unsigned rx_stall   = 0;
  int unsigned hold_cnt   = 0;
  bit          burst_mode     = 0;
  bit          long_hold_req  = 0;
  bit          long_hold_done = 0;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic out_word_t predict_intercept(in_word_t w);
    logic signed [127:0] px, py, pz, dx, dy, dz;
    logic signed [127:0] r2, bval, bmag, rad, tol, up2, lo2, disc, root, cand, dist_v;
    out_word_t res;
    res = '0;
    px = $signed(w.pos_x); py = $signed(w.pos_y); pz = $signed(w.pos_z);
    dx = $signed(w.dir_x); dy = $signed(w.dir_y); dz = $signed(w.dir_z);
    r2   = px * px + py * py + pz * pz;
    bval = (px * dx + py * dy + pz * dz) >>> DIR_FRAC;  // floor
    rad  = $signed({97'd0, radius_q});
    tol  = $signed({112'd0, tol_q});
    up2  = (rad + tol) * (rad + tol);
    lo2  = (rad >= tol) ? (rad - tol) * (rad - tol) : 128'sd0;
    // origin on the surface
    if (r2 < up2 && (rad < tol || lo2 < r2)) return res;
    bmag = (bval < 0) ? -bval : bval;
    disc = bmag * bmag + rad * rad - r2;
    if (disc < 0) return res;
    root = 0;
    for (int b = 63; b >= 0; b--) begin
      cand = root | (128'sd1 <<< b);
      if (cand * cand <= disc) root = cand;
    end
    if (bval < 0) begin
      res.hit = 1'b1;
      dist_v = (bmag > root) ? bmag - root : bmag + root;
    end else if (root > bmag) begin
      res.hit = 1'b1;
      dist_v = root - bmag;
    end
    if (res.hit) begin
      if (dist_v > 128'sh0_FFFF_FFFF) begin
        res.distance  = '1;
        res.saturated = 1'b1;
      end else begin
        res.distance = dist_v[31:0];
      end
    end
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
      tx_gap     <= 0;
    end else if (!(in_valid_i && !in_ready_o)) begin
      if (in_valid_i) hit_queue.push_back(predict_intercept(in_word_i));
      if (tx_gap > 0) begin
        tx_gap     <= tx_gap - 1;
        in_valid_i <= 1'b0;
      end else if (ray_queue.size() > 0) begin
        in_word_i  <= ray_queue.pop_front();
        in_valid_i <= 1'b1;
        tx_gap     <= pick_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t exp_w;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_stall    <= 0;
      hold_cnt    <= 0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (hit_queue.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word %p", out_word_o);
        end else begin
          exp_w = hit_queue.pop_front();
          if (exp_w.hit !== out_word_o.hit || exp_w.distance !== out_word_o.distance ||
              exp_w.saturated !== out_word_o.saturated) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp hit=%0b dist=%h sat=%0b got hit=%0b dist=%h sat=%0b",
                       exp_w.hit, exp_w.distance, exp_w.saturated,
                       out_word_o.hit, out_word_o.distance, out_word_o.saturated);
          end
        end
      end
      if (long_hold_req && !long_hold_done) begin
        out_ready_i <= 1'b0;
        hold_cnt    <= hold_cnt + 1;
        if (hold_cnt >= LONG_HOLD) long_hold_done <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall    <= rx_stall - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        if (out_valid_o && out_ready_i) rx_stall <= pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic wait_idle();
    while (ray_queue.size() > 0 || in_valid_i || hit_queue.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic idx, logic [CFG_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    if (idx == CFG_RADIUS) radius_q = data[RADIUS_W-1:0];
    else tol_q = data[TOL_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t make_ray(logic signed [31:0] px, logic signed [31:0] py,
                                        logic signed [31:0] pz, logic signed [31:0] dx,
                                        logic signed [31:0] dy, logic signed [31:0] dz);
    in_word_t w;
    w.pos_x = px; w.pos_y = py; w.pos_z = pz;
    w.dir_x = dx; w.dir_y = dy; w.dir_z = dz;
    return w;
  endfunction

  // well-formed ray near the sphere, or raw bits now and then
  function automatic in_word_t random_ray();
    in_word_t w;
    longint span;
    if ($urandom_range(0, 99) < 20) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      return w;
    end
    span = (radius_q == 0) ? 64'd65536 : 64'(radius_q) * 3;
    if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
    w.pos_x = 32'($signed(64'($urandom_range(0, 32'(2 * span)))) - span);
    w.pos_y = 32'($signed(64'($urandom_range(0, 32'(2 * span)))) - span);
    w.pos_z = 32'($signed(64'($urandom_range(0, 32'(2 * span)))) - span);
    w.dir_x = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    w.dir_y = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    w.dir_z = $signed($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000;
    return w;
  endfunction

  initial begin
    localparam logic signed [31:0] ONE  = 32'sh0001_0000;
    localparam logic signed [31:0] UNIT = 32'sh4000_0000;
    localparam logic signed [31:0] PMAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] PMIN = 32'sh8000_0000;
    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_RADIUS;
    cfg_data_i = '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // directed rays at reset settings: radius 1.0, tolerance 1
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
    ray_queue.push_back(make_ray(-3 * ONE, 0, 0, UNIT, 0, 0));      // hit from outside
    ray_queue.push_back(make_ray(-3 * ONE, 0, 0, -UNIT, 0, 0));     // pointing away
    ray_queue.push_back(make_ray(0, ONE / 2, 0, 0, UNIT, 0));       // inside
    ray_queue.push_back(make_ray(0, 0, ONE, 0, 0, UNIT));           // on surface
    ray_queue.push_back(make_ray(0, 0, ONE + 1, 0, 0, -UNIT));      // on the tolerance bound, counted outside
    ray_queue.push_back(make_ray(0, 0, ONE + 2, 0, 0, -UNIT));      // just outside tolerance
    ray_queue.push_back(make_ray(-3 * ONE, 2 * ONE, 0, UNIT, 0, 0)); // d < 0
    ray_queue.push_back(make_ray(-3 * ONE, ONE, 0, UNIT, 0, 0));    // tangent
    ray_queue.push_back(make_ray(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
    ray_queue.push_back(make_ray(PMIN, PMIN, PMIN, PMAX, PMAX, PMAX));
    ray_queue.push_back(make_ray(PMIN, PMIN, PMIN, PMIN, PMIN, PMIN));
    ray_queue.push_back(make_ray(PMAX, 0, 0, PMIN, 0, 0));
    ray_queue.push_back(make_ray(-3 * ONE, 0, 0, 2 * UNIT, 0, 0));  // non-unit direction
    ray_queue.push_back(make_ray(-1, -1, -1, -1, -1, -1));
    wait_idle();

    // largest radius: saturation and far roots
    cfg_write(CFG_RADIUS, 31'h7FFF_FFFF);
    cfg_write(CFG_TOL, 31'h7FFF_0000);
    ray_queue.push_back(make_ray(PMIN, 0, 0, PMAX, 0, 0));
    ray_queue.push_back(make_ray(-32'sh4000_0000, 0, 0, PMAX, 0, 0));
    ray_queue.push_back(make_ray(0, 0, 0, UNIT, UNIT, UNIT));
    ray_queue.push_back(make_ray(PMAX, PMAX, PMAX, PMIN, PMIN, PMIN));
    ray_queue.push_back(make_ray(0, 0, 0, 0, 0, 0));
    wait_idle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin cfg_write(CFG_RADIUS, 31'd65536 * 4); cfg_write(CFG_TOL, 31'd0); end
        1: begin cfg_write(CFG_RADIUS, 31'd0); cfg_write(CFG_TOL, 31'd0); end
        2: begin cfg_write(CFG_RADIUS, 31'd1000); cfg_write(CFG_TOL, 31'd65535); end
        3: begin cfg_write(CFG_RADIUS, 31'h7FFF_FFFF); cfg_write(CFG_TOL, CFG_W'($urandom)); end
        default: begin
          cfg_write(CFG_RADIUS, CFG_W'($urandom_range(0, 32'h0100_0000)));
          cfg_write(CFG_TOL, CFG_W'($urandom));
        end
      endcase
      burst_mode = (ph == 1);
      if (ph == 2) long_hold_req = 1'b1;  // receiver stalls long, input backs up
      for (int n = 0; n < 250; n++) ray_queue.push_back(random_ray());
      wait_idle();  // sender pauses until everything is back
    end

    wait_idle();
    if (mismatches == 0 && hit_queue.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
